FILE: src/assert_macros.svh
// Assertion helpers included by sorted_timestamp_nearest_search.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

FILE: src/stns_pkg.sv
`default_nettype none

package stns_pkg;

    // Operation codes carried in s_tuser
    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_SEARCH = 3'd2,
        OP_READ   = 3'd3,
        OP_LAST   = 3'd4,
        OP_COUNT  = 3'd5
    } op_t;

    // Result status codes carried in m_tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIRST = 6'b000010,
        S_LAST  = 6'b000100,
        S_PROBE = 6'b001000,
        S_PICK  = 6'b010000,
        S_READ  = 6'b100000
    } state_t;

    localparam int OP_W   = 3;
    localparam int TIME_W = 32;
    localparam int TAG_W  = 32;
    localparam int PKEY_W = 12;
    localparam int POS_W  = 13;
    localparam int STAT_W = 2;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 80;

    // One result word
    typedef struct packed {
        status_t             status;
        logic [POS_W-1:0]    pos;
        logic [TIME_W-1:0]   ftime;
        logic [TAG_W-1:0]    tag;
    } result_t;

endpackage

`default_nettype wire

FILE: src/sorted_timestamp_nearest_search.sv
// Sorted timestamp table with nearest-record search.
// Input words arrive on s_* (operation in s_tuser); one result word per input
// leaves on m_* (status in m_tuser). report_id should be written through
// cfg_* only while the block is idle; the block does not enforce this.
// cfg_ready is always high. Append, clear, last position, count and rejected
// items give their result in the cycle after acceptance. A read by position
// goes through one registered memory read and the S_READ state. A time
// search reads the first and last record, then probes the table midpoint by
// midpoint, one memory read per cycle, then picks the nearer bound.
// One item is in work at a time; s_tready is high only when the sequencer is
// idle and the result register is empty or being emptied.
// When m_tready is low the result word holds in the output register and no
// new word is taken. Reset empties the table (record count zero), clears
// report_id and drops any pending result; the record memories need no
// clearing pass since only positions below the count are ever read.
`default_nettype none

`include "assert_macros.svh"

module sorted_timestamp_nearest_search
    import stns_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_data,         // report_id
    // input words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,  // time_key[31:0], record_tag[63:32],
                                                // position_key[75:64], zero pad
    input  wire logic [OP_W-1:0]      s_tuser,  // op[2:0]
    // result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,  // found_position[12:0], found_time[44:13],
                                                // found_tag[76:45], zero pad
    output logic [STAT_W-1:0]         m_tuser   // status[1:0]
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Record memories
    logic [TIME_W-1:0] time_mem [TABLE_DEPTH];
    logic [TAG_W-1:0]  tag_mem  [TABLE_DEPTH];

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               report_id_reg;
    logic [AW-1:0]      lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [TIME_W-1:0]  lo_time_reg, lo_time_next, hi_time_reg, hi_time_next;
    logic [TAG_W-1:0]   lo_tag_reg, lo_tag_next, hi_tag_reg, hi_tag_next;
    logic [TIME_W-1:0]  key_reg, key_next;
    logic [AW-1:0]      pkey_reg, pkey_next;
    logic               m_valid_reg, m_valid_next;
    result_t            res_reg, res_next;

    logic [TIME_W-1:0]  rd_time_reg;
    logic [TAG_W-1:0]   rd_tag_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;

    logic               out_free;
    logic               s_accept;
    op_t                op_in;
    logic [TIME_W-1:0]  time_in;
    logic [TAG_W-1:0]   tag_in;
    logic [PKEY_W-1:0]  pkey_in;
    logic               narrow_step;
    logic [AW-1:0]      span;
    logic [AW-1:0]      mid_calc;
    logic [TIME_W-1:0]  dist_lo, dist_hi;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign op_in   = op_t'(s_tuser);
    assign time_in = s_tdata[TIME_W-1:0];
    assign tag_in  = s_tdata[TIME_W+TAG_W-1:TIME_W];
    assign pkey_in = s_tdata[TIME_W+TAG_W+PKEY_W-1:TIME_W+TAG_W];

    assign dist_lo = key_reg - lo_time_reg;
    assign dist_hi = hi_time_reg - key_reg;

    // Sequencer and result formation
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        lo_time_next  = lo_time_reg;
        hi_time_next  = hi_time_reg;
        lo_tag_next   = lo_tag_reg;
        hi_tag_next   = hi_tag_reg;
        key_next      = key_reg;
        pkey_next     = pkey_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        res_next      = res_reg;
        rd_addr       = '0;
        wr_en         = 1'b0;
        narrow_step   = 1'b0;
        span          = '0;
        mid_calc      = '0;

        case (state_reg)
            S_IDLE: begin
                rd_addr = (op_in == OP_READ) ? AW'(pkey_in) : '0;
                if (s_accept) begin
                    key_next     = time_in;
                    pkey_next    = AW'(pkey_in);
                    lo_next      = '0;
                    m_valid_next = 1'b1;
                    res_next     = '{status: ST_OK, pos: '0, ftime: '0, tag: '0};
                    case (op_in)
                        OP_APPEND: begin
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                res_next.pos = POS_W'(count_reg);
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_SEARCH: begin
                            if (count_reg == '0) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                m_valid_next = 1'b0;
                                state_next   = S_FIRST;
                            end
                        end
                        OP_READ: begin
                            if (count_reg == '0) begin
                                res_next.status = ST_EMPTY;
                            end else if (32'(pkey_in) >= 32'(count_reg)) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                m_valid_next = 1'b0;
                                state_next   = S_READ;
                            end
                        end
                        OP_LAST: begin
                            if (count_reg == '0) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                res_next.pos = POS_W'(count_reg - 1'b1);
                            end
                        end
                        OP_COUNT: begin
                            res_next.pos = POS_W'(count_reg);
                        end
                        default: begin
                            res_next.status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_FIRST: begin
                // hold the first record, fetch the last
                lo_time_next = rd_time_reg;
                lo_tag_next  = rd_tag_reg;
                hi_next      = AW'(count_reg - 1'b1);
                rd_addr      = AW'(count_reg - 1'b1);
                state_next   = S_LAST;
            end
            S_LAST: begin
                hi_time_next = rd_time_reg;
                hi_tag_next  = rd_tag_reg;
                if (key_reg < lo_time_reg || key_reg > rd_time_reg) begin
                    m_valid_next = 1'b1;
                    res_next     = '{status: ST_RANGE, pos: '0, ftime: '0, tag: '0};
                    state_next   = S_IDLE;
                end else begin
                    narrow_step = 1'b1;
                end
            end
            S_PROBE: begin
                // move the bound on the side of the probe
                if (key_reg < rd_time_reg) begin
                    hi_next      = mid_reg;
                    hi_time_next = rd_time_reg;
                    hi_tag_next  = rd_tag_reg;
                end else begin
                    lo_next      = mid_reg;
                    lo_time_next = rd_time_reg;
                    lo_tag_next  = rd_tag_reg;
                end
                narrow_step = 1'b1;
            end
            S_PICK: begin
                // take the lower bound on a tie
                m_valid_next    = 1'b1;
                res_next.status = ST_OK;
                if (dist_lo <= dist_hi) begin
                    res_next.pos   = report_id_reg ? '0 : POS_W'(lo_reg);
                    res_next.ftime = lo_time_reg;
                    res_next.tag   = report_id_reg ? lo_tag_reg : '0;
                end else begin
                    res_next.pos   = report_id_reg ? '0 : POS_W'(hi_reg);
                    res_next.ftime = hi_time_reg;
                    res_next.tag   = report_id_reg ? hi_tag_reg : '0;
                end
                state_next = S_IDLE;
            end
            S_READ: begin
                m_valid_next = 1'b1;
                res_next     = '{status: ST_OK, pos: POS_W'(pkey_reg),
                                 ftime: rd_time_reg, tag: rd_tag_reg};
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Issue the next midpoint probe or finish the search
        if (narrow_step) begin
            span     = hi_next - lo_next;
            mid_calc = lo_next + (span >> 1);
            if (span > AW'(1)) begin
                mid_next   = mid_calc;
                rd_addr    = mid_calc;
                state_next = S_PROBE;
            end else begin
                state_next = S_PICK;
            end
        end
    end

    // Memory write on append, registered read every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_mem[count_reg[AW-1:0]] <= time_in;
            tag_mem[count_reg[AW-1:0]]  <= tag_in;
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_tag_reg  <= tag_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            report_id_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                report_id_reg <= cfg_data;
            end
        end
    end

    // Search and result payload
    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        lo_time_reg <= lo_time_next;
        hi_time_reg <= hi_time_next;
        lo_tag_reg  <= lo_tag_next;
        hi_tag_reg  <= hi_tag_next;
        key_reg     <= key_next;
        pkey_reg    <= pkey_next;
        res_reg     <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {(M_DATA_W - POS_W - TIME_W - TAG_W)'(0),
                       res_reg.tag, res_reg.ftime, res_reg.pos};

    `ASSERT_NEVER(a_count_bound, count_reg > CW'(TABLE_DEPTH), "record count above table depth")
    `ASSERT_CLK(a_probe_inside, (state_reg == S_PROBE) |-> (lo_reg < mid_reg && mid_reg < hi_reg), "probe outside search bounds")
    `ASSERT_NEVER(a_busy_no_result, (state_reg != S_IDLE) && m_valid_reg, "result pending while sequencer busy")
    `ASSERT_CLK(a_result_source, $rose(m_valid_reg) |-> ($past(s_accept) || $past(state_reg != S_IDLE)), "result word without an item")

endmodule

`default_nettype wire
